@@ rtl/sgm_pkg.sv @@
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types, codes and default sizes for the grid membership block.
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int GRID_W_DEF       = 32;
  localparam int GRID_H_DEF       = 32;
  localparam int TILE_PIX_DEF     = 32;
  localparam int CELL_CAP_DEF     = 8;
  localparam int MAX_ENTITIES_DEF = 256;
  localparam int OUT_MAX          = 8;

  localparam logic [1:0] REQ_REG  = 2'd0;
  localparam logic [1:0] REQ_MOVE = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OFF   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         entity_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [9:0]         box_w;
    logic [9:0]         box_h;
    logic [9:0]         cell_index;
  } sgm_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] cover_start;
    logic [9:0] cover_end;
    logic [7:0] member_id;
    logic       last;
  } sgm_out_t;

  typedef enum logic [2:0] {
    EM_BAD_ENT, EM_OFF, EM_DONE, EM_RD_BAD, EM_RD_EMPTY, EM_RD_MEM
  } emit_t;

  typedef enum logic [1:0] {SLOT_I, SLOT_CNT, SLOT_NM1} slot_t;

  typedef enum logic [1:0] {CW_ZERO, CW_INC, CW_DEC} cntw_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_DIV_GO, S_DIV_WAIT, S_ENT_RD, S_CHK,
    S_INS_TEST, S_INS_UPD, S_REM_INIT, S_REM_TEST, S_REM_CNT, S_REM_RDM,
    S_REM_CMP, S_REM_WR, S_FIN, S_EMIT, S_RD_CHK, S_RD_CNT, S_RD_MEM, S_RD_OUT
  } state_t;

  typedef struct packed {
    logic  load;
    logic  div_go;
    logic  div_cap;
    logic  ent_rd;
    logic  ent_wr;
    logic  st_clr;
    logic  st_full;
    logic  loop_init;
    logic  loop_adv;
    logic  phase_old;
    logic  cnt_rd;
    logic  cnt_wr;
    cntw_t cnt_wsel;
    logic  clr_mode;
    logic  clr_adv;
    logic  n_cap;
    logic  i_clr;
    logic  i_inc;
    logic  mem_rd;
    logic  mem_wr;
    slot_t rd_slot;
    slot_t wr_slot;
    logic  mem_wmove;
    logic  emit;
    emit_t emit_kind;
  } sgm_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       k_last;
    logic [1:0] req_type;
    logic       eid_bad;
    logic       off;
    logic       skip;
    logic       at_end;
    logic       cnt_full;
    logic       cnt_zero;
    logic       i_eq_n;
    logic       match;
    logic       nm1_eq_i;
    logic       rd_last;
    logic       ci_bad;
    logic       clr_last;
    logic       out_free;
  } sgm_sts_t;

endpackage

@@ rtl/sgm_div.sv @@
// ----------------------------------------------------------------------------
// sgm_div
// Divider by a constant using a reciprocal multiply. The quotient is
// truncated toward zero and is ready in the cycle after start.
// ----------------------------------------------------------------------------
module sgm_div #(
  parameter int DIVISOR = sgm_pkg::TILE_PIX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [17:0] dividend,
  output logic               done,
  output logic signed [17:0] quot
);

  // magnitude is below 2^17; ceil(2^(17+l)/d) with l = ceil(log2 d) is exact
  localparam int          LG    = $clog2(DIVISOR);
  localparam int          SH    = 17 + LG;
  localparam logic [17:0] RECIP = 18'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [16:0]        mag;
  logic [34:0]        prod;
  logic [16:0]        qmag;
  logic               done_r;
  logic signed [17:0] quot_r;

  assign mag  = dividend[17] ? 17'(-dividend) : dividend[16:0];
  assign prod = 35'(mag) * 35'(RECIP);
  assign qmag = 17'(prod >> SH);

  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else done_r <= start;
  end

  always_ff @(posedge clk) begin
    if (start) quot_r <= dividend[17] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

@@ rtl/sgm_datapath.sv @@
// ----------------------------------------------------------------------------
// sgm_datapath
// Request registers, divider, cell count and member memories, entity cover
// memory, cell walk counters and the output register.
// ----------------------------------------------------------------------------
module sgm_datapath #(
  parameter int GRID_W       = sgm_pkg::GRID_W_DEF,
  parameter int GRID_H       = sgm_pkg::GRID_H_DEF,
  parameter int TILE_PIX     = sgm_pkg::TILE_PIX_DEF,
  parameter int CELL_CAP     = sgm_pkg::CELL_CAP_DEF,
  parameter int MAX_ENTITIES = sgm_pkg::MAX_ENTITIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sgm_pkg::sgm_in_t  in_data,
  input  sgm_pkg::sgm_cmd_t cmd,
  output sgm_pkg::sgm_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output sgm_pkg::sgm_out_t out_data
);

  localparam int NCELLS    = GRID_W * GRID_H;
  localparam int CELL_AW   = $clog2(NCELLS);
  localparam int MEM_AW    = $clog2(NCELLS * CELL_CAP);
  localparam int XW        = $clog2(GRID_W);
  localparam int YW        = $clog2(GRID_H);
  localparam int CNTW      = $clog2(CELL_CAP + 1);
  localparam int ENT_DEPTH = (MAX_ENTITIES < 256) ? MAX_ENTITIES : 256;
  localparam int EAW       = $clog2(ENT_DEPTH);
  localparam int RW        = 2 * (XW + YW);
  localparam logic signed [17:0] W_S = 18'(GRID_W);
  localparam logic signed [17:0] H_S = 18'(GRID_H);

  function automatic logic [16:0] cidx(input logic [XW-1:0] x, input logic [YW-1:0] y);
    return 17'(y) * 17'(GRID_W) + 17'(x);
  endfunction

  sgm_pkg::sgm_in_t  req_r;
  sgm_pkg::sgm_out_t out_r;
  logic              out_valid_r;
  logic [1:0]        k_r;
  logic signed [17:0] q_r [4];
  logic [1:0]        st_r;

  // divider
  logic signed [17:0] dvd, adj, quot;
  logic              div_done;

  assign adj = (req_r.req_type == sgm_pkg::REQ_MOVE) ? 18'(TILE_PIX - 1) : 18'sd0;

  always_comb begin
    case (k_r)
      2'd0:    dvd = 18'(req_r.pos_x);
      2'd1:    dvd = 18'(req_r.pos_y);
      2'd2:    dvd = 18'(req_r.pos_x) + $signed({8'b0, req_r.box_w}) + adj;
      default: dvd = 18'(req_r.pos_y) + $signed({8'b0, req_r.box_h}) + adj;
    endcase
  end

  sgm_div #(.DIVISOR(TILE_PIX)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (dvd),
    .done     (div_done),
    .quot     (quot)
  );

  // new rectangle, clamped
  logic [XW-1:0] cx0, cx1, ox0, ox1, lx0, lx1, x_r;
  logic [YW-1:0] cy0, cy1, oy0, oy1, ly0, ly1, y_r;
  logic          off;

  assign off = (q_r[2] < 0) || (q_r[3] < 0) || (q_r[0] >= W_S) || (q_r[1] >= H_S);
  assign cx0 = (q_r[0] < 0) ? '0 : q_r[0][XW-1:0];
  assign cy0 = (q_r[1] < 0) ? '0 : q_r[1][YW-1:0];
  assign cx1 = (q_r[2] >= W_S) ? XW'(GRID_W - 1) : q_r[2][XW-1:0];
  assign cy1 = (q_r[3] >= H_S) ? YW'(GRID_H - 1) : q_r[3][YW-1:0];

  // entity cover store; never-written entries read as the zero rectangle
  logic [RW-1:0]        ent_mem [ENT_DEPTH];
  logic [ENT_DEPTH-1:0] ent_vld_r;
  logic [RW-1:0]        ent_q_r;
  logic                 ent_vq_r;
  logic [EAW-1:0]       eaddr;

  assign eaddr = req_r.entity_id[EAW-1:0];
  assign {ox0, oy0, ox1, oy1} = ent_vq_r ? ent_q_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.ent_wr) ent_mem[eaddr] <= {cx0, cy0, cx1, cy1};
    if (cmd.ent_rd) ent_q_r <= ent_mem[eaddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      ent_vq_r  <= 1'b0;
    end else begin
      if (cmd.ent_wr) ent_vld_r[eaddr] <= 1'b1;
      if (cmd.ent_rd) ent_vq_r <= ent_vld_r[eaddr];
    end
  end

  // cell walk
  logic inside_old, inside_new;

  assign lx0 = cmd.phase_old ? ox0 : cx0;
  assign lx1 = cmd.phase_old ? ox1 : cx1;
  assign ly0 = cmd.phase_old ? oy0 : cy0;
  assign ly1 = cmd.phase_old ? oy1 : cy1;
  assign inside_old = (x_r >= ox0) && (x_r <= ox1) && (y_r >= oy0) && (y_r <= oy1);
  assign inside_new = (x_r >= cx0) && (x_r <= cx1) && (y_r >= cy0) && (y_r <= cy1);

  always_ff @(posedge clk) begin
    if (cmd.loop_init) begin
      x_r <= lx0;
      y_r <= ly0;
    end else if (cmd.loop_adv) begin
      if (x_r == lx1) begin
        x_r <= lx0;
        y_r <= y_r + 1'b1;
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
  end

  // cell count and member stores
  logic [CNTW-1:0]    cnt_mem [NCELLS];
  logic [7:0]         mem_arr [NCELLS * CELL_CAP];
  logic [CNTW-1:0]    cnt_q_r, n_r, i_r, cnt_wd;
  logic [7:0]         mem_q_r, mem_wd;
  logic [CELL_AW-1:0] clr_r, cell_sel, cnt_addr;
  logic [16:0]        ci17, cur_idx;
  logic [22:0]        rd_a, wr_a;
  logic [CNTW-1:0]    rd_s, wr_s, nm1;

  assign ci17     = 17'(req_r.cell_index);
  assign cur_idx  = cidx(x_r, y_r);
  assign cell_sel = (req_r.req_type == sgm_pkg::REQ_READ) ? ci17[CELL_AW-1:0]
                                                          : cur_idx[CELL_AW-1:0];
  assign cnt_addr = cmd.clr_mode ? clr_r : cell_sel;
  assign nm1      = n_r - 1'b1;

  always_comb begin
    case (cmd.cnt_wsel)
      sgm_pkg::CW_INC: cnt_wd = cnt_q_r + 1'b1;
      sgm_pkg::CW_DEC: cnt_wd = nm1;
      default:         cnt_wd = '0;
    endcase
    case (cmd.rd_slot)
      sgm_pkg::SLOT_CNT: rd_s = cnt_q_r;
      sgm_pkg::SLOT_NM1: rd_s = nm1;
      default:           rd_s = i_r;
    endcase
    case (cmd.wr_slot)
      sgm_pkg::SLOT_CNT: wr_s = cnt_q_r;
      sgm_pkg::SLOT_NM1: wr_s = nm1;
      default:           wr_s = i_r;
    endcase
  end

  assign rd_a   = 23'(cell_sel) * 23'(CELL_CAP) + 23'(rd_s);
  assign wr_a   = 23'(cell_sel) * 23'(CELL_CAP) + 23'(wr_s);
  assign mem_wd = cmd.mem_wmove ? mem_q_r : req_r.entity_id;

  always_ff @(posedge clk) begin
    if (cmd.cnt_wr) cnt_mem[cnt_addr] <= cnt_wd;
    if (cmd.cnt_rd) cnt_q_r <= cnt_mem[cnt_addr];
    if (cmd.mem_wr) mem_arr[wr_a[MEM_AW-1:0]] <= mem_wd;
    if (cmd.mem_rd) mem_q_r <= mem_arr[rd_a[MEM_AW-1:0]];
  end

  // request capture and small counters
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    if (cmd.div_cap) q_r[k_r] <= quot;
    if (cmd.st_clr) st_r <= sgm_pkg::ST_OK;
    else if (cmd.st_full) st_r <= sgm_pkg::ST_FULL;
    if (cmd.n_cap) n_r <= cnt_q_r;
    if (cmd.i_clr) i_r <= '0;
    else if (cmd.i_inc) i_r <= i_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.load) k_r <= '0;
      else if (cmd.div_cap) k_r <= k_r + 2'd1;
      if (cmd.clr_adv) clr_r <= clr_r + 1'b1;
    end
  end

  // read-out length
  logic [7:0] n8, nlim8;
  logic       rd_last;

  assign n8      = 8'(n_r);
  assign nlim8   = (n8 > 8'(sgm_pkg::OUT_MAX)) ? 8'(sgm_pkg::OUT_MAX) : n8;
  assign rd_last = (8'(i_r) + 8'd1) == nlim8;

  // output register
  logic [16:0] os_i, oe_i, ns_i, ne_i;
  logic        out_free;

  assign os_i     = cidx(ox0, oy0);
  assign oe_i     = cidx(ox1, oy1);
  assign ns_i     = cidx(cx0, cy0);
  assign ne_i     = cidx(cx1, cy1);
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.member_id <= 8'd0;
      out_r.last      <= 1'b1;
      case (cmd.emit_kind)
        sgm_pkg::EM_OFF: begin
          out_r.status      <= sgm_pkg::ST_OFF;
          out_r.cover_start <= os_i[9:0];
          out_r.cover_end   <= oe_i[9:0];
        end
        sgm_pkg::EM_DONE: begin
          out_r.status      <= st_r;
          out_r.cover_start <= ns_i[9:0];
          out_r.cover_end   <= ne_i[9:0];
        end
        sgm_pkg::EM_RD_BAD: begin
          out_r.status      <= sgm_pkg::ST_OFF;
          out_r.cover_start <= req_r.cell_index;
          out_r.cover_end   <= req_r.cell_index;
        end
        sgm_pkg::EM_RD_EMPTY: begin
          out_r.status      <= sgm_pkg::ST_EMPTY;
          out_r.cover_start <= req_r.cell_index;
          out_r.cover_end   <= req_r.cell_index;
        end
        sgm_pkg::EM_RD_MEM: begin
          out_r.status      <= sgm_pkg::ST_OK;
          out_r.cover_start <= req_r.cell_index;
          out_r.cover_end   <= req_r.cell_index;
          out_r.member_id   <= mem_q_r;
          out_r.last        <= rd_last;
        end
        default: begin
          out_r.status      <= sgm_pkg::ST_OFF;
          out_r.cover_start <= '0;
          out_r.cover_end   <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status back to the controller
  assign sts.div_done = div_done;
  assign sts.k_last   = (k_r == 2'd3);
  assign sts.req_type = req_r.req_type;
  assign sts.eid_bad  = 13'(req_r.entity_id) >= 13'(MAX_ENTITIES);
  assign sts.off      = off;
  assign sts.skip     = cmd.phase_old ? inside_new
                                      : ((req_r.req_type == sgm_pkg::REQ_MOVE) && inside_old);
  assign sts.at_end   = (x_r == lx1) && (y_r == ly1);
  assign sts.cnt_full = cnt_q_r >= CNTW'(CELL_CAP);
  assign sts.cnt_zero = (cnt_q_r == '0);
  assign sts.i_eq_n   = (i_r == n_r);
  assign sts.match    = (mem_q_r == req_r.entity_id);
  assign sts.nm1_eq_i = (nm1 == i_r);
  assign sts.rd_last  = rd_last;
  assign sts.ci_bad   = ci17 >= 17'(NCELLS);
  assign sts.clr_last = (clr_r == CELL_AW'(NCELLS - 1));
  assign sts.out_free = out_free;

endmodule

@@ rtl/sgm_ctrl.sv @@
// ----------------------------------------------------------------------------
// sgm_ctrl
// Request sequencer: count clearing, division, cell walks for insert and
// remove, cell read-out and result hand-off.
// ----------------------------------------------------------------------------
module sgm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sgm_pkg::sgm_sts_t sts,
  output sgm_pkg::sgm_cmd_t cmd
);

  sgm_pkg::state_t state_r, state_nxt;
  sgm_pkg::emit_t  kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgm_pkg::S_CLEAR;
      kind_r  <= sgm_pkg::EM_BAD_ENT;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cmd           = '0;
    cmd.emit_kind = kind_r;
    in_stall      = 1'b1;
    unique case (state_r)
      sgm_pkg::S_CLEAR: begin
        cmd.clr_mode = 1'b1;
        cmd.cnt_wr   = 1'b1;
        cmd.cnt_wsel = sgm_pkg::CW_ZERO;
        cmd.clr_adv  = 1'b1;
        if (sts.clr_last) state_nxt = sgm_pkg::S_IDLE;
      end
      sgm_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sgm_pkg::S_DECODE;
        end
      end
      sgm_pkg::S_DECODE: begin
        if (sts.req_type == sgm_pkg::REQ_NONE) state_nxt = sgm_pkg::S_IDLE;
        else if (sts.req_type == sgm_pkg::REQ_READ) state_nxt = sgm_pkg::S_RD_CHK;
        else if (sts.eid_bad) begin
          kind_nxt  = sgm_pkg::EM_BAD_ENT;
          state_nxt = sgm_pkg::S_EMIT;
        end else state_nxt = sgm_pkg::S_DIV_GO;
      end
      sgm_pkg::S_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = sgm_pkg::S_DIV_WAIT;
      end
      sgm_pkg::S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          state_nxt   = sts.k_last ? sgm_pkg::S_ENT_RD : sgm_pkg::S_DIV_GO;
        end
      end
      sgm_pkg::S_ENT_RD: begin
        cmd.ent_rd = 1'b1;
        state_nxt  = sgm_pkg::S_CHK;
      end
      sgm_pkg::S_CHK: begin
        if (sts.off) begin
          kind_nxt  = sgm_pkg::EM_OFF;
          state_nxt = sgm_pkg::S_EMIT;
        end else begin
          cmd.st_clr    = 1'b1;
          cmd.loop_init = 1'b1;
          state_nxt     = sgm_pkg::S_INS_TEST;
        end
      end
      sgm_pkg::S_INS_TEST: begin
        if (sts.skip) begin
          cmd.loop_adv = 1'b1;
          if (sts.at_end)
            state_nxt = (sts.req_type == sgm_pkg::REQ_MOVE) ? sgm_pkg::S_REM_INIT
                                                            : sgm_pkg::S_FIN;
        end else begin
          cmd.cnt_rd = 1'b1;
          state_nxt  = sgm_pkg::S_INS_UPD;
        end
      end
      sgm_pkg::S_INS_UPD: begin
        if (sts.cnt_full) cmd.st_full = 1'b1;
        else begin
          cmd.mem_wr   = 1'b1;
          cmd.wr_slot  = sgm_pkg::SLOT_CNT;
          cmd.cnt_wr   = 1'b1;
          cmd.cnt_wsel = sgm_pkg::CW_INC;
        end
        cmd.loop_adv = 1'b1;
        if (sts.at_end)
          state_nxt = (sts.req_type == sgm_pkg::REQ_MOVE) ? sgm_pkg::S_REM_INIT
                                                          : sgm_pkg::S_FIN;
        else state_nxt = sgm_pkg::S_INS_TEST;
      end
      sgm_pkg::S_REM_INIT: begin
        cmd.phase_old = 1'b1;
        cmd.loop_init = 1'b1;
        state_nxt     = sgm_pkg::S_REM_TEST;
      end
      sgm_pkg::S_REM_TEST: begin
        cmd.phase_old = 1'b1;
        if (sts.skip) begin
          cmd.loop_adv = 1'b1;
          if (sts.at_end) state_nxt = sgm_pkg::S_FIN;
        end else begin
          cmd.cnt_rd = 1'b1;
          state_nxt  = sgm_pkg::S_REM_CNT;
        end
      end
      sgm_pkg::S_REM_CNT: begin
        cmd.phase_old = 1'b1;
        cmd.n_cap     = 1'b1;
        cmd.i_clr     = 1'b1;
        if (sts.cnt_zero) begin
          cmd.loop_adv = 1'b1;
          state_nxt    = sts.at_end ? sgm_pkg::S_FIN : sgm_pkg::S_REM_TEST;
        end else state_nxt = sgm_pkg::S_REM_RDM;
      end
      sgm_pkg::S_REM_RDM: begin
        cmd.phase_old = 1'b1;
        if (sts.i_eq_n) begin
          // entity not listed in this cell
          cmd.loop_adv = 1'b1;
          state_nxt    = sts.at_end ? sgm_pkg::S_FIN : sgm_pkg::S_REM_TEST;
        end else begin
          cmd.mem_rd  = 1'b1;
          cmd.rd_slot = sgm_pkg::SLOT_I;
          state_nxt   = sgm_pkg::S_REM_CMP;
        end
      end
      sgm_pkg::S_REM_CMP: begin
        cmd.phase_old = 1'b1;
        if (sts.match) begin
          cmd.cnt_wr   = 1'b1;
          cmd.cnt_wsel = sgm_pkg::CW_DEC;
          if (!sts.nm1_eq_i) begin
            // pull the last entry into the freed slot
            cmd.mem_rd  = 1'b1;
            cmd.rd_slot = sgm_pkg::SLOT_NM1;
            state_nxt   = sgm_pkg::S_REM_WR;
          end else begin
            cmd.loop_adv = 1'b1;
            state_nxt    = sts.at_end ? sgm_pkg::S_FIN : sgm_pkg::S_REM_TEST;
          end
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = sgm_pkg::S_REM_RDM;
        end
      end
      sgm_pkg::S_REM_WR: begin
        cmd.phase_old = 1'b1;
        cmd.mem_wr    = 1'b1;
        cmd.wr_slot   = sgm_pkg::SLOT_I;
        cmd.mem_wmove = 1'b1;
        cmd.loop_adv  = 1'b1;
        state_nxt     = sts.at_end ? sgm_pkg::S_FIN : sgm_pkg::S_REM_TEST;
      end
      sgm_pkg::S_FIN: begin
        cmd.ent_wr = 1'b1;
        kind_nxt   = sgm_pkg::EM_DONE;
        state_nxt  = sgm_pkg::S_EMIT;
      end
      sgm_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sgm_pkg::S_IDLE;
        end
      end
      sgm_pkg::S_RD_CHK: begin
        if (sts.ci_bad) begin
          kind_nxt  = sgm_pkg::EM_RD_BAD;
          state_nxt = sgm_pkg::S_EMIT;
        end else begin
          cmd.cnt_rd = 1'b1;
          state_nxt  = sgm_pkg::S_RD_CNT;
        end
      end
      sgm_pkg::S_RD_CNT: begin
        cmd.n_cap = 1'b1;
        cmd.i_clr = 1'b1;
        if (sts.cnt_zero) begin
          kind_nxt  = sgm_pkg::EM_RD_EMPTY;
          state_nxt = sgm_pkg::S_EMIT;
        end else state_nxt = sgm_pkg::S_RD_MEM;
      end
      sgm_pkg::S_RD_MEM: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_slot = sgm_pkg::SLOT_I;
        state_nxt   = sgm_pkg::S_RD_OUT;
      end
      sgm_pkg::S_RD_OUT: begin
        cmd.emit_kind = sgm_pkg::EM_RD_MEM;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.rd_last) state_nxt = sgm_pkg::S_IDLE;
          else begin
            cmd.i_inc = 1'b1;
            state_nxt = sgm_pkg::S_RD_MEM;
          end
        end
      end
      default: state_nxt = sgm_pkg::S_IDLE;
    endcase
  end

endmodule

@@ rtl/spatial_grid_membership.sv @@
// ----------------------------------------------------------------------------
// spatial_grid_membership
// Uniform grid broad-phase store: per-cell member lists, per-entity cover.
// ----------------------------------------------------------------------------
// After reset the block zeroes every cell count and holds in_stall high.
// One item is worked at a time. Register and move run four divisions by
// TILE_PIX through a reciprocal multiply, one after another, and then walk
// the covered cells through the count memory port; a move also walks the
// old rectangle, scanning each list member by member for the entity. A read
// fetches the cell count and then returns the members one at a time.
// Results leave through an output register, so the next item is taken while
// the last result waits.
module spatial_grid_membership #(
  parameter int GRID_W       = sgm_pkg::GRID_W_DEF,
  parameter int GRID_H       = sgm_pkg::GRID_H_DEF,
  parameter int TILE_PIX     = sgm_pkg::TILE_PIX_DEF,
  parameter int CELL_CAP     = sgm_pkg::CELL_CAP_DEF,
  parameter int MAX_ENTITIES = sgm_pkg::MAX_ENTITIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sgm_pkg::sgm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sgm_pkg::sgm_out_t out_data
);

  sgm_pkg::sgm_cmd_t cmd;
  sgm_pkg::sgm_sts_t sts;

  sgm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sgm_datapath #(
    .GRID_W       (GRID_W),
    .GRID_H       (GRID_H),
    .TILE_PIX     (TILE_PIX),
    .CELL_CAP     (CELL_CAP),
    .MAX_ENTITIES (MAX_ENTITIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
